/* hw/rtl/imuoc_pkg.sv */
// shared types, constants and register indexes for the imu offset calibrator
`default_nettype none
package imuoc_pkg;

    localparam int ACCEL_SHIFT = 5;
    localparam int GYRO_SHIFT  = 3;
    localparam int MAX_SHIFT   = (ACCEL_SHIFT > GYRO_SHIFT) ? ACCEL_SHIFT : GYRO_SHIFT;
    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = SAMPLE_W + MAX_SHIFT;
    localparam int NUM_AXES    = 6;
    localparam int NUM_ACCEL   = 3;
    localparam int AZ_LANE     = 2;
    localparam int GRAV_W      = 15;
    localparam int PERIOD_W    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GRAV_W-1:0]   GRAVITY_RESET = 15'd16384;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 8'd100;
    localparam logic signed [SAMPLE_W-1:0] OFF_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] OFF_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY  = 4'd0,
        REG_PERIOD   = 4'd1,
        REG_START_AX = 4'd2,
        REG_START_AY = 4'd3,
        REG_START_AZ = 4'd4,
        REG_START_GX = 4'd5,
        REG_START_GY = 4'd6,
        REG_START_GZ = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] acc_x;
        logic signed [SAMPLE_W-1:0] acc_y;
        logic signed [SAMPLE_W-1:0] acc_z;
        logic signed [SAMPLE_W-1:0] rot_x;
        logic signed [SAMPLE_W-1:0] rot_y;
        logic signed [SAMPLE_W-1:0] rot_z;
    } t_imu_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg_ax;
        logic signed [SAMPLE_W-1:0] avg_ay;
        logic signed [SAMPLE_W-1:0] avg_az;
        logic signed [SAMPLE_W-1:0] avg_gx;
        logic signed [SAMPLE_W-1:0] avg_gy;
        logic signed [SAMPLE_W-1:0] avg_gz;
        logic signed [SAMPLE_W-1:0] new_off_ax;
        logic signed [SAMPLE_W-1:0] new_off_ay;
        logic signed [SAMPLE_W-1:0] new_off_az;
        logic signed [SAMPLE_W-1:0] new_off_gx;
        logic signed [SAMPLE_W-1:0] new_off_gy;
        logic signed [SAMPLE_W-1:0] new_off_gz;
    } t_imu_result;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg;
        logic signed [SAMPLE_W-1:0] off;
    } t_lane_res;

    typedef struct packed {
        logic sample_en;
        logic fire;
        logic reload;
    } t_lane_ctrl;

endpackage
`default_nettype wire

/* hw/rtl/imuoc_lane.sv */
// one axis: shift-based exponential average and offset stepper
`default_nettype none
module imuoc_lane
    import imuoc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_gyro,
    input  wire t_lane_ctrl                 i_ctrl,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_start_off,
    input  wire logic [GRAV_W-1:0]          i_target,
    output t_lane_res                       o_res
);

    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    w_old_avg;
    logic signed [ACC_W-1:0]    w_new_avg;
    logic signed [SAMPLE_W-1:0] r_off;
    logic signed [SAMPLE_W-1:0] n_off;
    logic                       w_above;

    always_comb begin
        if (i_gyro) begin
            w_old_avg = r_acc >>> GYRO_SHIFT;
        end else begin
            w_old_avg = r_acc >>> ACCEL_SHIFT;
        end
        // true sum stays inside the accumulator range, so wrapping is exact
        n_acc = r_acc - w_old_avg + ACC_W'(i_sample);
        if (i_gyro) begin
            w_new_avg = n_acc >>> GYRO_SHIFT;
        end else begin
            w_new_avg = n_acc >>> ACCEL_SHIFT;
        end
        w_above = $signed({w_new_avg[SAMPLE_W-1], w_new_avg[SAMPLE_W-1:0]})
                > $signed({2'b00, i_target});
        if (w_above) begin
            n_off = (r_off == OFF_MIN) ? r_off : r_off - SAMPLE_W'(1);
        end else begin
            n_off = (r_off == OFF_MAX) ? r_off : r_off + SAMPLE_W'(1);
        end
    end

    assign o_res.avg = w_new_avg[SAMPLE_W-1:0];
    assign o_res.off = n_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_off <= '0;
        end else begin
            if (i_ctrl.sample_en) begin
                r_acc <= n_acc;
            end
            if (i_ctrl.reload) begin
                r_off <= i_start_off;
            end else if (i_ctrl.sample_en && i_ctrl.fire) begin
                r_off <= n_off;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/imuoc_merge.sv */
// gathers the six lane results into one output transaction register
`default_nettype none
module imuoc_merge
    import imuoc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_take,
    input  wire t_lane_res i_res [NUM_AXES],
    input  wire logic      i_out_ready,
    output logic           o_out_valid,
    output t_imu_result    o_result,
    output logic           o_busy
);

    logic        r_valid;
    t_imu_result r_result;
    t_imu_result n_result;

    always_comb begin
        n_result.avg_ax     = i_res[0].avg;
        n_result.avg_ay     = i_res[1].avg;
        n_result.avg_az     = i_res[2].avg;
        n_result.avg_gx     = i_res[3].avg;
        n_result.avg_gy     = i_res[4].avg;
        n_result.avg_gz     = i_res[5].avg;
        n_result.new_off_ax = i_res[0].off;
        n_result.new_off_ay = i_res[1].off;
        n_result.new_off_az = i_res[2].off;
        n_result.new_off_gx = i_res[3].off;
        n_result.new_off_gy = i_res[4].off;
        n_result.new_off_gz = i_res[5].off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;
    // a held result that is not taken this cycle blocks a new one
    assign o_busy      = r_valid && !i_out_ready;

endmodule
`default_nettype wire

/* hw/rtl/imu_offset_calibrator.sv */
// top level of the six-axis imu offset calibrator
//
// Takes one six-axis sample per clock when ready. Each axis runs in its own
// lane: an exponential average (shift 5 for accelerometer, 3 for gyro) and
// an offset that steps by one when the sample counter fires, down if the
// average is above its target, else up. A fire yields one output transaction
// with the six averages and new offsets, held in an output register until
// taken; samples that produce no result keep flowing while it waits, and
// only a sample that would fire waits for the register to free. Any valid
// configuration write to a known index reloads all offsets from the start
// registers; the configuration port is always ready.
`default_nettype none
module imu_offset_calibrator
    import imuoc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_imu_sample           i_sample,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_imu_result                o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [GRAV_W-1:0]          r_gravity;
    logic [PERIOD_W-1:0]        r_period;
    logic [PERIOD_W-1:0]        r_count;
    logic signed [SAMPLE_W-1:0] r_start [NUM_AXES];
    logic signed [SAMPLE_W-1:0] n_start [NUM_AXES];
    logic signed [SAMPLE_W-1:0] w_x     [NUM_AXES];
    t_lane_res                  w_res   [NUM_AXES];
    t_lane_ctrl                 w_ctrl;
    logic                       w_cfg_we;
    logic                       w_cfg_known;
    logic                       w_fire;
    logic                       w_accept;
    logic                       w_busy;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    always_comb begin
        case (t_cfg_idx'(i_cfg_index))
            REG_GRAVITY, REG_PERIOD, REG_START_AX, REG_START_AY,
            REG_START_AZ, REG_START_GX, REG_START_GY, REG_START_GZ: begin
                w_cfg_known = 1'b1;
            end
            default: begin
                w_cfg_known = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
            r_period  <= PERIOD_RESET;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_start[k] <= '0;
            end
        end else if (w_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_GRAVITY: begin
                    r_gravity <= i_cfg_data[GRAV_W-1:0];
                end
                REG_PERIOD: begin
                    r_period <= i_cfg_data[PERIOD_W-1:0];
                end
                default: begin
                    for (int k = 0; k < NUM_AXES; k++) begin
                        r_start[k] <= n_start[k];
                    end
                end
            endcase
        end
    end

    // start values as they stand after this cycle's write, used for the reload
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (w_cfg_we &&
                i_cfg_index == CFG_IDX_W'(REG_START_AX) + CFG_IDX_W'(k)) begin
                n_start[k] = $signed(i_cfg_data[SAMPLE_W-1:0]);
            end else begin
                n_start[k] = r_start[k];
            end
        end
    end

    assign w_fire     = (r_count == r_period);
    assign o_in_ready = !(w_busy && w_fire);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= w_fire ? PERIOD_W'(1) : r_count + PERIOD_W'(1);
        end
    end

    assign w_ctrl.sample_en = w_accept;
    assign w_ctrl.fire      = w_fire;
    assign w_ctrl.reload    = w_cfg_we && w_cfg_known;

    assign w_x[0] = i_sample.acc_x;
    assign w_x[1] = i_sample.acc_y;
    assign w_x[2] = i_sample.acc_z;
    assign w_x[3] = i_sample.rot_x;
    assign w_x[4] = i_sample.rot_y;
    assign w_x[5] = i_sample.rot_z;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        imuoc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_gyro      ((g >= NUM_ACCEL) ? 1'b1 : 1'b0),
            .i_ctrl      (w_ctrl),
            .i_sample    (w_x[g]),
            .i_start_off (n_start[g]),
            .i_target    ((g == AZ_LANE) ? r_gravity : GRAV_W'(0)),
            .o_res       (w_res[g])
        );
    end

    imuoc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_accept && w_fire),
        .i_res       (w_res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (o_result),
        .o_busy      (w_busy)
    );

endmodule
`default_nettype wire
